/* hw/rtl/lfu_pkg.sv */
// Shared widths, codes and controller/datapath handshake types for the LFU cache.
package lfu_pkg;

  localparam int KEY_W          = 32;
  localparam int VALUE_W        = 32;
  localparam int CAP_W          = 5;
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic respond;
    logic upd_rd;
    logic commit;
  } lfu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic out_free;
    logic need_update;
  } lfu_sts_t;

endpackage

/* hw/rtl/lfu_ifs.sv */
// Valid/ready channel interfaces: request, response and capacity write.
interface lfu_req_if;
  import lfu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [KEY_W-1:0]          key;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [VALUE_W-1:0] read_value;
  logic                      evicted;
  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

interface lfu_cfg_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/lfu_cache_lru_tiebreak.sv */
// Top level of the LFU key/value cache with least-recently-used tie break.
//
// Channels: req takes one word {action, key, value} (get or put), rsp returns
// one word {hit, read_value, evicted} per request, cfg writes active_capacity.
// cfg is always ready; write it only while no request is in flight.
// Sequence: a request is taken in IDLE, then one RAM read per entry scans
// every entry (key match, victim, first free slot), a tail step drains the
// RAM read register and the decide step loads the rsp register. A get miss,
// or any request at capacity zero, is done there. A hit or a put adds a
// write-back sweep that shifts recency ranks, bumps counts and writes the
// new entry. The entry RAM's single read port sets the pace of both sweeps.
// rsp is a holding register: the next request is taken while a result still
// waits; if rsp is still stalled when the next result is ready, the block
// holds in its decide step until the receiver takes the older word.
// Reset (synchronous, rst high) empties the cache and sets the capacity to 16;
// entry RAM contents are not cleared, valid bits gate every read.
module lfu_cache_lru_tiebreak #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lfu_req_if.sink      req,
  lfu_rsp_if.source    rsp,
  lfu_cfg_if.sink      cfg
);
  import lfu_pkg::*;

  lfu_cmd_t cmd;
  lfu_sts_t sts;

  // capacity writes are accepted any time
  assign cfg.ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lfu_dp #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (req.action),
    .in_key        (req.key),
    .in_value      (req.value),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.data),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_hit       (rsp.hit),
    .out_read_value(rsp.read_value),
    .out_evicted   (rsp.evicted)
  );

endmodule

/* hw/rtl/lfu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/lfu_ctrl.sv */
// Sequencer: lookup scan, result hand-off, then, when an update is needed, rank/count write-back sweep.
module lfu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lfu_pkg::lfu_sts_t sts,
  output lfu_pkg::lfu_cmd_t cmd
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_TAIL,
    S_DECIDE,
    S_UPD,
    S_UPD_TAIL
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.idx_last) state <= S_SCAN_TAIL;
        end
        S_SCAN_TAIL: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts.out_free) state <= sts.need_update ? S_UPD : S_IDLE;
        end
        S_UPD: begin
          if (sts.idx_last) state <= S_UPD_TAIL;
        end
        S_UPD_TAIL: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    in_ready    = (state == S_IDLE);
    cmd.capture = in_ready && in_valid;
    cmd.scan_rd = (state == S_SCAN);
    cmd.respond = (state == S_DECIDE) && sts.out_free;
    cmd.upd_rd  = (state == S_UPD);
    cmd.commit  = (state == S_UPD_TAIL);
  end

endmodule

/* hw/rtl/lfu_dp.sv */
// Datapath: entry RAM, scan trackers, replacement decision and output register.
module lfu_dp #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lfu_pkg::lfu_cmd_t                  cmd,
  output lfu_pkg::lfu_sts_t                  sts,
  input  logic                               in_action,
  input  logic [lfu_pkg::KEY_W-1:0]          in_key,
  input  logic signed [lfu_pkg::VALUE_W-1:0] in_value,
  input  logic                               cfg_valid,
  input  logic [lfu_pkg::CAP_W-1:0]          cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic signed [lfu_pkg::VALUE_W-1:0] out_read_value,
  output logic                               out_evicted
);
  import lfu_pkg::*;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int CNT_LSB = RANK_W;
  localparam int DAT_LSB = CNT_LSB + COUNT_BITS;
  localparam int KEY_LSB = DAT_LSB + VALUE_W;
  localparam int REC_W   = KEY_LSB + KEY_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [IDX_W-1:0]      IDX_END = IDX_W'(ENTRIES - 1);

  // control state
  logic [CAP_W-1:0]   cap_reg;
  logic [ENTRIES-1:0] valid;
  logic [OCC_W-1:0]   occ;
  logic [IDX_W-1:0]   idx;
  logic               scan_pend;
  logic               upd_pend;

  // current word
  logic                act_q;
  logic [KEY_W-1:0]    key_q;
  logic [VALUE_W-1:0]  val_q;
  logic [IDX_W-1:0]    pend_idx;

  // scan trackers
  logic                hit_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic [VALUE_W-1:0]  hit_data_q;
  logic [RANK_W-1:0]   hit_rank_q;
  logic                vic_found_q;
  logic [IDX_W-1:0]    vic_idx_q;
  logic [COUNT_BITS-1:0] vic_cnt_q;
  logic [RANK_W-1:0]   vic_rank_q;
  logic                free_found_q;
  logic [IDX_W-1:0]    free_idx_q;

  // latched decision for the write-back sweep
  logic                mode_hit_q;
  logic                evict_q;
  logic [IDX_W-1:0]    ins_idx_q;

  // RAM
  logic                ram_we;
  logic [REC_W-1:0]    ram_wdata;
  logic [REC_W-1:0]    ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [VALUE_W-1:0]  rd_data;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [RANK_W-1:0]   rd_rank;
  logic [COUNT_BITS-1:0] cnt_inc;

  // decision
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    cap_eff;
  logic                cap_zero;
  logic                dec_hit;
  logic                dec_evict;
  logic                dec_update;
  logic [VALUE_W-1:0]  dec_rd;
  logic [IDX_W-1:0]    dec_ins;

  lfu_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pend_idx),
    .wdata(ram_wdata),
    .re   (cmd.scan_rd || cmd.upd_rd),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  assign rd_key  = ram_rdata[KEY_LSB +: KEY_W];
  assign rd_data = ram_rdata[DAT_LSB +: VALUE_W];
  assign rd_cnt  = ram_rdata[CNT_LSB +: COUNT_BITS];
  assign rd_rank = ram_rdata[RANK_W-1:0];
  assign cnt_inc = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE;

  // replacement decision from the finished scan
  always_comb begin
    cap_ext    = CMP_W'(cap_reg);
    cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    cap_zero   = (cap_eff == '0);
    dec_hit    = !cap_zero && hit_q;
    dec_evict  = !cap_zero && (act_q == ACT_PUT) && !hit_q && (CMP_W'(occ) >= cap_eff);
    dec_update = !cap_zero && (hit_q || (act_q == ACT_PUT));
    dec_rd     = (dec_hit && (act_q == ACT_GET)) ? hit_data_q : MISS_VALUE;
    if (dec_evict) begin
      dec_ins = (free_found_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q;
    end else begin
      dec_ins = free_idx_q;
    end
  end

  always_comb begin
    sts.idx_last    = (idx == IDX_END);
    sts.out_free    = !out_valid || out_ready;
    sts.need_update = dec_update;
  end

  // write-back of one entry per cycle during the sweep
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    if (upd_pend) begin
      if (mode_hit_q) begin
        if (pend_idx == hit_idx_q) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_key, (act_q == ACT_PUT) ? val_q : rd_data, cnt_inc, RANK_W'(0)};
        end else if (valid[pend_idx]) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_key, rd_data, rd_cnt,
                       (rd_rank < hit_rank_q) ? rd_rank + RANK_W'(1) : rd_rank};
        end
      end else begin
        if (pend_idx == ins_idx_q) begin
          ram_we    = 1'b1;
          ram_wdata = {key_q, val_q, CNT_ONE, RANK_W'(0)};
        end else if (valid[pend_idx] && !(evict_q && (pend_idx == vic_idx_q))) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_key, rd_data, rd_cnt,
                       (evict_q && (rd_rank > vic_rank_q)) ? rd_rank : rd_rank + RANK_W'(1)};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg   <= CAP_RESET;
      valid     <= '0;
      occ       <= '0;
      idx       <= '0;
      scan_pend <= 1'b0;
      upd_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) cap_reg <= cfg_data;
      scan_pend <= cmd.scan_rd;
      upd_pend  <= cmd.upd_rd;
      if (cmd.capture || cmd.respond) begin
        idx <= '0;
      end else if (cmd.scan_rd || cmd.upd_rd) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.respond) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit && !mode_hit_q) begin
        if (evict_q) valid[vic_idx_q] <= 1'b0;
        valid[ins_idx_q] <= 1'b1;
        if (!evict_q) occ <= occ + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.upd_rd) pend_idx <= idx;
    if (cmd.capture) begin
      act_q        <= in_action;
      key_q        <= in_key;
      val_q        <= in_value;
      hit_q        <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (scan_pend) begin
      if (valid[pend_idx]) begin
        if (rd_key == key_q) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= pend_idx;
          hit_data_q <= rd_data;
          hit_rank_q <= rd_rank;
        end
        // lowest count wins, older entry wins a tie
        if (!vic_found_q || (rd_cnt < vic_cnt_q) ||
            ((rd_cnt == vic_cnt_q) && (rd_rank > vic_rank_q))) begin
          vic_found_q <= 1'b1;
          vic_idx_q   <= pend_idx;
          vic_cnt_q   <= rd_cnt;
          vic_rank_q  <= rd_rank;
        end
      end else if (!free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= pend_idx;
      end
    end
    if (cmd.respond) begin
      out_hit        <= dec_hit;
      out_read_value <= dec_rd;
      out_evicted    <= dec_evict;
      mode_hit_q     <= hit_q;
      evict_q        <= dec_evict;
      ins_idx_q      <= dec_ins;
    end
  end

endmodule

/* tb/lfu_cache_checker.sv */
// Checker for the LFU cache: watches all channels, predicts each reply and compares it.
module lfu_cache_checker #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lfu_req_if          req,
  lfu_rsp_if          rsp,
  lfu_cfg_if          cfg,
  output int unsigned errors,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  typedef struct packed {
    logic                      hit;
    logic signed [VALUE_W-1:0] read_value;
    logic                      evicted;
  } cache_reply_t;

  localparam logic [COUNT_BITS-1:0] USES_MAX = '1;

  cache_reply_t          replies_due[$];
  logic                  line_valid [ENTRIES];
  logic [KEY_W-1:0]      line_key   [ENTRIES];
  logic [VALUE_W-1:0]    line_data  [ENTRIES];
  logic [COUNT_BITS-1:0] line_uses  [ENTRIES];
  int unsigned           line_age   [ENTRIES];  // 0 = most recently touched
  int unsigned           fill;
  logic [CAP_W-1:0]      capacity;

  // Hit on a line: move it to the front, count saturates.
  function automatic void bump(int e);
    int unsigned r;
    r = line_age[e];
    for (int i = 0; i < ENTRIES; i++)
      if (line_valid[i] && line_age[i] < r) line_age[i]++;
    line_age[e] = 0;
    if (line_uses[e] != USES_MAX) line_uses[e]++;
  endfunction

  function automatic cache_reply_t predict_access(logic act, logic [KEY_W-1:0] k,
                                                  logic [VALUE_W-1:0] v);
    cache_reply_t rep;
    int           e;
    int           victim;
    int           slot;
    int           eff;
    int unsigned  r;
    rep.hit        = 1'b0;
    rep.read_value = MISS_VALUE;
    rep.evicted    = 1'b0;
    eff = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
    if (eff == 0) return rep;  // storage hidden, nothing changes

    e = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (e < 0 && line_valid[i] && line_key[i] == k) e = i;

    if (e >= 0) begin
      rep.hit = 1'b1;
      if (act == ACT_GET) rep.read_value = line_data[e];
      else line_data[e] = v;
      bump(e);
    end else if (act == ACT_PUT) begin
      if (fill >= eff) begin
        // lowest count, then least recent
        victim = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!line_valid[i]) continue;
          if (victim < 0 || line_uses[i] < line_uses[victim] ||
              (line_uses[i] == line_uses[victim] && line_age[i] > line_age[victim]))
            victim = i;
        end
        if (victim >= 0) begin
          r = line_age[victim];
          line_valid[victim] = 1'b0;
          for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_age[i] > r) line_age[i]--;
          if (fill > 0) fill--;
        end
        rep.evicted = 1'b1;
      end
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !line_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (line_valid[i]) line_age[i]++;
        line_valid[slot] = 1'b1;
        line_key[slot]   = k;
        line_data[slot]  = v;
        line_uses[slot]  = 1;
        line_age[slot]   = 0;
        fill++;
      end
    end
    return rep;
  endfunction

  always @(posedge clk) begin
    cache_reply_t exp_rep;
    if (rst) begin
      replies_due.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_age[i]   = 0;
      end
      fill     = 0;
      capacity = CAP_RESET;
      errors   = 0;
    end else begin
      // reply first, so a word taken this edge never pairs with a request of the same edge
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected reply word: hit=%0b read_value=%0d evicted=%0b",
                     rsp.hit, rsp.read_value, rsp.evicted);
          errors++;
        end else begin
          exp_rep = replies_due.pop_front();
          if (rsp.hit !== exp_rep.hit || rsp.read_value !== exp_rep.read_value ||
              rsp.evicted !== exp_rep.evicted) begin
            if (errors < 10)
              $display("reply mismatch: exp %0b/%0d/%0b got %0b/%0d/%0b",
                       exp_rep.hit, exp_rep.read_value, exp_rep.evicted,
                       rsp.hit, rsp.read_value, rsp.evicted);
            errors++;
          end
        end
      end
      if (cfg.valid && cfg.ready) capacity = cfg.data;
      if (req.valid && req.ready)
        replies_due.push_back(predict_access(req.action, req.key, req.value));
    end
    pending = replies_due.size();
  end

endmodule

/* tb/lfu_cache_lru_tiebreak_tb.sv */
// Testbench top for the LFU cache: clock, reset, stimulus, back-pressure, watchdog, verdict.
module lfu_cache_lru_tiebreak_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int COUNT_BITS  = COUNT_BITS_DEF;
  // A hit or put keeps sweeping the entries after its reply word is out.
  localparam int SETTLE      = 2 * ENTRIES + 8;
  localparam int IDLE_LIMIT  = 4000;
  localparam int ITEM_TARGET = 1150;
  localparam int POOL        = 24;

  logic        clk;
  logic        rst;
  bit          calm;         // when set, neither side idles
  int unsigned err_count;
  int unsigned pending;
  int unsigned idle_cycles;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();
  lfu_cfg_if cfg_ch ();

  lfu_cache_lru_tiebreak #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  lfu_cache_checker #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .cfg     (cfg_ch),
    .errors  (err_count),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One request word. Valid stays high after the accept; the next call either
  // drives the next word at the following falling edge or drops valid for a gap.
  task automatic send_access(input logic act, input logic [KEY_W-1:0] k,
                             input logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      req_ch.key   = $urandom;  // junk payload while idle
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid  = 1'b1;
    req_ch.action = act;
    req_ch.key    = k;
    req_ch.value  = v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop sending and wait until every reply is back and the write-back sweep is over.
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = c;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Reply side: ready runs of random length broken by stalls.
  initial begin
    int unsigned hold;
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    forever begin
      hold = $urandom_range(1, 24);
      repeat (hold) begin
        @(negedge clk);
        rsp_ch.ready = 1'b1;
      end
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        rsp_ch.ready = 1'b0;
      end
    end
  end

  // Watchdog: too long without any word moving on any channel.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool [POOL];
    logic [CAP_W-1:0] c;
    logic [KEY_W-1:0] k;
    logic             act;
    int unsigned      items_sent;
    int unsigned      phase;
    int unsigned      eff;
    int unsigned      span;
    int unsigned      n;
    int unsigned      r;

    calm          = 1'b0;
    items_sent    = 0;
    req_ch.valid  = 1'b0;
    req_ch.action = ACT_GET;
    req_ch.key    = '0;
    req_ch.value  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    rst           = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed: reset capacity of 16 ----
    send_access(ACT_GET, 32'h0000_0000, 32'sd0);              // miss on an empty cache
    send_access(ACT_PUT, 32'h0000_0000, 32'sh7fff_ffff);
    send_access(ACT_PUT, 32'hffff_ffff, 32'sh8000_0000);
    send_access(ACT_GET, 32'h0000_0000, 32'sd0);
    send_access(ACT_GET, 32'hffff_ffff, -32'sd1);
    send_access(ACT_PUT, 32'h0000_0000, -32'sd1);              // update in place
    send_access(ACT_GET, 32'h0000_0000, 32'sd0);              // stored -1 reads like a miss value
    send_access(ACT_GET, 32'h0000_0001, 32'sd0);
    send_access(ACT_PUT, 32'h0000_0001, 32'sd0);

    // capacity zero: contents kept but invisible, puts do nothing
    write_capacity(5'd0);
    send_access(ACT_GET, 32'h0000_0000, 32'sd0);
    send_access(ACT_PUT, 32'h0000_0002, 32'sd5);
    send_access(ACT_GET, 32'h0000_0002, 32'sd0);

    // capacity below occupancy: no flush, each new key evicts exactly one
    write_capacity(5'd2);
    send_access(ACT_GET, 32'hffff_ffff, 32'sd0);
    send_access(ACT_PUT, 32'h0000_0003, 32'sd3);              // lowest count goes
    send_access(ACT_GET, 32'h0000_0001, 32'sd0);
    send_access(ACT_PUT, 32'h0000_0004, 32'sd4);

    // capacity above the entry count is clamped
    write_capacity(5'd31);
    send_access(ACT_PUT, 32'h0000_0006, 32'sd6);
    send_access(ACT_PUT, 32'h0000_0007, 32'sd7);

    // equal counts: the oldest of keys 4, 6 and 7, key 4, is the victim
    write_capacity(5'd5);
    send_access(ACT_PUT, 32'h0000_0008, 32'sd8);
    send_access(ACT_GET, 32'h0000_0006, 32'sd0);
    send_access(ACT_GET, 32'h0000_0007, 32'sd0);

    // ---- random phases, one capacity each ----
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < POOL; i++) key_pool[i] = $urandom;

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: c = 5'd1;
        1: c = 5'd16;
        2: c = 5'd31;
        3: c = 5'd0;
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0) c = 5'd0;
          else if (r == 1) c = 5'd31;
          else if (r == 2) c = 5'd16;
          else c = CAP_W'($urandom_range(1, 15));
        end
      endcase
      write_capacity(c);

      // key pool a little larger than the capacity keeps hits and evictions both common
      eff  = (c > ENTRIES) ? ENTRIES : c;
      span = eff + $urandom_range(1, 6);
      if (span > POOL) span = POOL;
      repeat ($urandom_range(0, 3)) key_pool[$urandom_range(2, POOL - 1)] = $urandom;
      calm = ($urandom_range(0, 3) == 0);
      n    = (c == 0) ? 15 : $urandom_range(40, 110);

      repeat (n) begin
        if ($urandom_range(0, 59) == 0) drain();
        if ($urandom_range(0, 99) < 88) k = key_pool[$urandom_range(0, span - 1)];
        else k = $urandom;
        act = ($urandom_range(0, 99) < 45) ? ACT_PUT : ACT_GET;
        send_access(act, k, $urandom);
        if (c != 0) items_sent++;
      end
      phase++;
    end

    calm = 1'b0;
    drain();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* lfu_cache_lru_tiebreak.f */
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ifs.sv
hw/rtl/lfu_ram.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_dp.sv
hw/rtl/lfu_cache_lru_tiebreak.sv
tb/lfu_cache_checker.sv
tb/lfu_cache_lru_tiebreak_tb.sv
